### sv/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg
// Types, codes and the bank remap function shared by the memory pager.
// ----------------------------------------------------------------------------
package bmp_pkg;

  typedef enum logic [1:0] {
    CMD_PORT_WR = 2'd0,
    CMD_MEM_RD  = 2'd1,
    CMD_MEM_WR  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODEL_16K    = 3'd0,
    MODEL_48K    = 3'd1,
    MODEL_128K   = 3'd2,
    MODEL_PLUS2  = 3'd3,
    MODEL_PLUS2A = 3'd4,
    MODEL_PLUS3  = 3'd5,
    MODEL_RSVD6  = 3'd6,
    MODEL_RSVD7  = 3'd7
  } model_t;

  typedef logic [7:0]       page_t;
  typedef page_t [3:0]      bank_map_t;

  localparam page_t       ROM_BASE      = 8'h80;
  localparam int unsigned LOCK_BIT      = 5;
  localparam logic [13:0] SCREEN_BYTES  = 14'd6912;
  localparam logic [15:0] PRI_MASK_OLD  = 16'h8002;
  localparam logic [15:0] PRI_MASK_NEW  = 16'hc002;
  localparam logic [15:0] PRI_MATCH_NEW = 16'h4000;
  localparam logic [15:0] SEC_MASK      = 16'hf002;
  localparam logic [15:0] SEC_MATCH     = 16'h1000;
  localparam logic [2:0]  VPAGE_NORMAL  = 3'd5;
  localparam logic [2:0]  VPAGE_SHADOW  = 3'd7;

  // Paging state as seen by the access that caused it.
  typedef struct packed {
    bank_map_t  banks;
    logic       locked;
    logic [2:0] vpage;
  } pager_view_t;

  typedef struct packed {
    page_t       page;
    logic [13:0] page_offset;
    logic        contended;
    logic        shows_screen;
    logic        write_allowed;
    logic        screen_write;
    logic        open_bus;
    logic        paging_locked;
    logic [2:0]  display_page;
  } result_t;

  function automatic bank_map_t remap_banks(input logic [7:0] pri, input logic [7:0] sec);
    bank_map_t m;
    m = '0;
    if (sec[0]) begin
      case (sec[2:1])
        2'd0:    m = {8'd3, 8'd2, 8'd1, 8'd0};
        2'd1:    m = {8'd7, 8'd6, 8'd5, 8'd4};
        2'd2:    m = {8'd3, 8'd6, 8'd5, 8'd4};
        default: m = {8'd3, 8'd6, 8'd7, 8'd4};
      endcase
    end else begin
      m[0] = ROM_BASE | {6'd0, sec[2], pri[4]};
      m[1] = 8'd5;
      m[2] = 8'd2;
      m[3] = {5'd0, pri[2:0]};
    end
    return m;
  endfunction

endpackage

### sv/banked_memory_pager.sv
// ----------------------------------------------------------------------------
// banked_memory_pager
// Bus-speed memory pager: translates each bus access to a physical page.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) carries one bus access per word:
//   a port write, a memory read or a memory write. Every access produces
//   exactly one result word on the output channel (out_valid/out_stall)
//   describing the bank that holds the address after any paging update.
//   An access is registered on acceptance, translated by combinational
//   logic between the input and output registers, and its result is held
//   in the output register. One access per cycle is sustained while the
//   receiver does not stall.
//   When the receiver stalls, the result stays put and the input register
//   still takes one more access; beyond that in_stall follows out_stall.
//   Reset clears the latches and lock, restores the normal bank layout and
//   selects the 48K model. cfg_wr_en/cfg_wr_data set the model while idle;
//   the user must keep to that, as the block does not enforce it.
// ----------------------------------------------------------------------------
module banked_memory_pager import bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_page,
  output logic [13:0] out_page_offset,
  output logic        out_contended,
  output logic        out_shows_screen,
  output logic        out_write_allowed,
  output logic        out_screen_write,
  output logic        out_open_bus,
  output logic        out_paging_locked,
  output logic [2:0]  out_display_page
);

  model_t      model_r;
  logic        s1_valid_r, s1_valid_nxt;
  cmd_t        s1_cmd_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r;
  result_t     res;
  pager_view_t view;
  logic        adv;
  logic        in_acc;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r     <= MODEL_48K;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        model_r <= model_t'(cfg_wr_data);
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= cmd_t'(in_command);
      s1_addr_r <= in_address;
      s1_data_r <= in_data;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  bmp_paging u_paging (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .cmd   (s1_cmd_r),
    .addr  (s1_addr_r),
    .data  (s1_data_r),
    .model (model_r),
    .view  (view)
  );

  bmp_lookup u_lookup (
    .view  (view),
    .cmd   (s1_cmd_r),
    .addr  (s1_addr_r),
    .model (model_r),
    .res   (res)
  );

  assign out_valid         = out_valid_r;
  assign out_page          = res_r.page;
  assign out_page_offset   = res_r.page_offset;
  assign out_contended     = res_r.contended;
  assign out_shows_screen  = res_r.shows_screen;
  assign out_write_allowed = res_r.write_allowed;
  assign out_screen_write  = res_r.screen_write;
  assign out_open_bus      = res_r.open_bus;
  assign out_paging_locked = res_r.paging_locked;
  assign out_display_page  = res_r.display_page;

endmodule

### sv/bmp_paging.sv
// ----------------------------------------------------------------------------
// bmp_paging
// Paging latches, sticky lock and bank map. Decodes port writes per model.
// ----------------------------------------------------------------------------
module bmp_paging import bmp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  cmd_t        cmd,
  input  logic [15:0] addr,
  input  logic [7:0]  data,
  input  model_t      model,
  output pager_view_t view
);

  logic [7:0] pri_r, pri_nxt;
  logic [7:0] sec_r, sec_nxt;
  logic       lock_r, lock_nxt;
  bank_map_t  banks_r, banks_nxt;
  logic       hit_pri, hit_sec;

  always_comb begin
    hit_pri = 1'b0;
    hit_sec = 1'b0;
    if (cmd == CMD_PORT_WR && !lock_r) begin
      if (model == MODEL_128K || model == MODEL_PLUS2) begin
        hit_pri = (addr & PRI_MASK_OLD) == 16'h0000;
      end else if (model != MODEL_16K && model != MODEL_48K) begin
        hit_pri = (addr & PRI_MASK_NEW) == PRI_MATCH_NEW;
        hit_sec = (addr & SEC_MASK) == SEC_MATCH;
      end
    end
    pri_nxt   = hit_pri ? data : pri_r;
    sec_nxt   = hit_sec ? data : sec_r;
    banks_nxt = banks_r;
    lock_nxt  = lock_r;
    if (hit_pri || hit_sec) begin
      banks_nxt = remap_banks(pri_nxt, sec_nxt);
      lock_nxt  = pri_nxt[LOCK_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_r   <= '0;
      sec_r   <= '0;
      lock_r  <= 1'b0;
      banks_r <= remap_banks(8'h00, 8'h00);
    end else if (fire) begin
      pri_r   <= pri_nxt;
      sec_r   <= sec_nxt;
      lock_r  <= lock_nxt;
      banks_r <= banks_nxt;
    end
  end

  assign view.banks  = banks_nxt;
  assign view.locked = lock_nxt;
  assign view.vpage  = pri_nxt[3] ? VPAGE_SHADOW : VPAGE_NORMAL;

endmodule

### sv/bmp_lookup.sv
// ----------------------------------------------------------------------------
// bmp_lookup
// Translates one access against the paging view into a result word.
// ----------------------------------------------------------------------------
module bmp_lookup import bmp_pkg::*; (
  input  pager_view_t view,
  input  cmd_t        cmd,
  input  logic [15:0] addr,
  input  model_t      model,
  output result_t     res
);

  page_t pg;
  logic  shows;
  logic  newer;

  always_comb begin
    pg    = view.banks[addr[15:14]];
    shows = pg == {5'd0, view.vpage};
    newer = !(model == MODEL_16K || model == MODEL_48K ||
              model == MODEL_128K || model == MODEL_PLUS2);

    res.page          = pg;
    res.page_offset   = addr[13:0];
    // Later models contend pages 4 to 7; earlier ones every odd RAM page.
    res.contended     = newer ? (pg[7:3] == 5'd0 && pg[2]) : (!pg[7] && pg[0]);
    res.shows_screen  = shows;
    res.write_allowed = !pg[7];
    res.screen_write  = cmd == CMD_MEM_WR && shows && addr[13:0] < SCREEN_BYTES;
    res.open_bus      = cmd == CMD_MEM_RD && model == MODEL_16K && addr[15];
    res.paging_locked = view.locked;
    res.display_page  = view.vpage;
  end

endmodule

### sv/bmp_checker.sv
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks for the memory pager, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_page,
  input logic [13:0] out_page_offset,
  input logic        out_shows_screen,
  input logic        out_write_allowed,
  input logic        out_screen_write,
  input logic        out_paging_locked
);

  logic seen_lock_r;

  // Once a result has reported the lock, only reset can release it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_lock_r <= 1'b0;
    end else if (out_valid && !out_stall && out_paging_locked) begin
      seen_lock_r <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_page) && $stable(out_page_offset))
    else $error("stalled result word changed");

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_lock_r |-> out_paging_locked)
    else $error("paging lock released without reset");

  a_rom_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_write_allowed == !out_page[7])
    else $error("write permission disagrees with page type");

  a_screen_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_screen_write |-> out_shows_screen && out_page_offset < 14'd6912)
    else $error("screen write flagged outside the screen area");

endmodule

bind banked_memory_pager bmp_checker u_bmp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_page          (out_page),
  .out_page_offset   (out_page_offset),
  .out_shows_screen  (out_shows_screen),
  .out_write_allowed (out_write_allowed),
  .out_screen_write  (out_screen_write),
  .out_paging_locked (out_paging_locked)
);
